>>> rtl/core/m6502_oar_pkg.sv
// Shared widths and addressing mode codes for the 6502 operand address resolver.
package m6502_oar_pkg;

  // Payload widths of the request and result channels.
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MODE_W = 4;

  // Addressing mode codes carried in the request mode field.
  localparam logic [MODE_W-1:0] M_IMM   = 4'd0;
  localparam logic [MODE_W-1:0] M_ZP    = 4'd1;
  localparam logic [MODE_W-1:0] M_ZP_X  = 4'd2;
  localparam logic [MODE_W-1:0] M_ZP_Y  = 4'd3;
  localparam logic [MODE_W-1:0] M_ABS   = 4'd4;
  localparam logic [MODE_W-1:0] M_ABS_X = 4'd5;
  localparam logic [MODE_W-1:0] M_ABS_Y = 4'd6;
  localparam logic [MODE_W-1:0] M_IND   = 4'd7;
  localparam logic [MODE_W-1:0] M_IND_X = 4'd8;
  localparam logic [MODE_W-1:0] M_IND_Y = 4'd9;

  // Command codes carried in the request cmd field.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

endpackage

>>> rtl/core/m6502_oar_req_if.sv
// Request channel: memory writes and resolve commands.
interface m6502_oar_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [m6502_oar_pkg::MODE_W-1:0]   mode;
  logic [m6502_oar_pkg::WORD_W-1:0]   start_pc;
  logic [m6502_oar_pkg::BYTE_W-1:0]   x_index;
  logic [m6502_oar_pkg::BYTE_W-1:0]   y_index;
  logic [m6502_oar_pkg::WORD_W-1:0]   mem_addr;
  logic [m6502_oar_pkg::BYTE_W-1:0]   mem_data;

  modport source (
    output valid, cmd, mode, start_pc, x_index, y_index, mem_addr, mem_data,
    input  ready
  );

  modport sink (
    input  valid, cmd, mode, start_pc, x_index, y_index, mem_addr, mem_data,
    output ready
  );
endinterface

>>> rtl/core/m6502_oar_rsp_if.sv
// Result channel: effective address, operand value, page cross and next PC.
interface m6502_oar_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [m6502_oar_pkg::WORD_W-1:0]   eff_addr;
  logic [m6502_oar_pkg::WORD_W-1:0]   operand_value;
  logic                               page_cross;
  logic [m6502_oar_pkg::WORD_W-1:0]   next_pc;

  modport source (
    output valid, eff_addr, operand_value, page_cross, next_pc,
    input  ready
  );

  modport sink (
    input  valid, eff_addr, operand_value, page_cross, next_pc,
    output ready
  );
endinterface

>>> rtl/core/mos6502_operand_address_resolver_unit.sv
// Top level of the 6502 operand address resolver with its byte memory.
//
//   Channel   Role   Payload
//   request   sink   cmd, mode, start_pc, x_index, y_index, mem_addr, mem_data
//   result    source eff_addr, operand_value, page_cross, next_pc
//
// One item at a time. Every memory read goes through the single RAM port; an item
// passes one sequencer state per dependent read on its way to S_DONE (a write or
// unknown mode goes there directly), which holds through any output stall.
// A new request transfer is taken whenever the sequencer is idle, even while
// the previous result still waits in the output register.
// Reset is synchronous and clears the sequencer and the output valid flag;
// memory contents are undefined until written.
module mos6502_operand_address_resolver_unit #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  m6502_oar_req_if.sink          request,
  m6502_oar_rsp_if.source        result
);

  localparam int unsigned MemDepth = 1 << ADDR_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_B0   = 3'd1;
  localparam logic [2:0] S_B1   = 3'd2;
  localparam logic [2:0] S_P0   = 3'd3;
  localparam logic [2:0] S_P1   = 3'd4;
  localparam logic [2:0] S_VAL  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state, state_next;
  logic [3:0]  mode_r, mode_r_next;
  logic [15:0] pc_r, pc_r_next;
  logic [7:0]  x_r, x_r_next;
  logic [7:0]  y_r, y_r_next;
  logic [7:0]  lo_r, lo_r_next;
  logic [15:0] ptr_r, ptr_r_next;
  logic [15:0] ea_r, ea_r_next;
  logic [15:0] val_r, val_r_next;
  logic        cross_r, cross_r_next;
  logic [15:0] npc_r, npc_r_next;

  logic        out_valid, out_valid_next;
  logic [15:0] out_ea, out_ea_next;
  logic [15:0] out_val, out_val_next;
  logic        out_cross, out_cross_next;
  logic [15:0] out_npc, out_npc_next;

  logic                 ram_we;
  logic [15:0]          ram_addr16;
  logic [7:0]           ram_rdata;
  logic [7:0]           idx_sel;
  logic [7:0]           add_idx;
  logic [7:0]           zp_sum;
  logic [15:0]          sum16;
  logic                 idx_cross;
  logic                 req_xfer;
  logic                 out_load;

  m6502_oar_ram #(
    .WIDTH (8),
    .DEPTH (MemDepth)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr16[ADDR_BITS-1:0]),
    .wdata (request.mem_data),
    .rdata (ram_rdata)
  );

  assign req_xfer      = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && (!out_valid || result.ready);

  // Index picked by the mode for the zero-page and absolute sums.
  always_comb begin
    case (mode_r)
      m6502_oar_pkg::M_ZP_X, m6502_oar_pkg::M_ABS_X, m6502_oar_pkg::M_IND_X: begin
        idx_sel = x_r;
      end
      m6502_oar_pkg::M_ZP_Y, m6502_oar_pkg::M_ABS_Y: begin
        idx_sel = y_r;
      end
      default: begin
        idx_sel = 8'h00;
      end
    endcase
  end

  // Shared adders: an 8-bit zero-page sum and a 16-bit indexed sum whose base
  // is the byte pair formed by the latched low byte and the RAM read data.
  assign zp_sum    = ram_rdata + idx_sel;
  assign add_idx   = (state == S_P1) ? ((mode_r == m6502_oar_pkg::M_IND_Y) ? y_r : 8'h00)
                                     : idx_sel;
  assign sum16     = {ram_rdata, lo_r} + {8'h00, add_idx};
  assign idx_cross = (sum16[15:8] != ram_rdata);

  // Sequencer: each state consumes the byte read in the previous cycle and
  // issues the next dependent read.
  always_comb begin
    state_next   = state;
    mode_r_next  = mode_r;
    pc_r_next    = pc_r;
    x_r_next     = x_r;
    y_r_next     = y_r;
    lo_r_next    = lo_r;
    ptr_r_next   = ptr_r;
    ea_r_next    = ea_r;
    val_r_next   = val_r;
    cross_r_next = cross_r;
    npc_r_next   = npc_r;
    ram_we       = 1'b0;
    ram_addr16   = (request.cmd == m6502_oar_pkg::CMD_RESOLVE) ? request.start_pc
                                                              : request.mem_addr;

    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          mode_r_next  = request.mode;
          pc_r_next    = request.start_pc;
          x_r_next     = request.x_index;
          y_r_next     = request.y_index;
          ea_r_next    = 16'h0000;
          val_r_next   = 16'h0000;
          cross_r_next = 1'b0;
          npc_r_next   = 16'h0000;
          if (request.cmd == m6502_oar_pkg::CMD_WRITE) begin
            ram_we     = 1'b1;
            state_next = S_DONE;
          end else if (request.mode inside {[m6502_oar_pkg::M_IMM:m6502_oar_pkg::M_IND_Y]})
          begin
            if (request.mode inside {m6502_oar_pkg::M_ABS, m6502_oar_pkg::M_ABS_X,
                                     m6502_oar_pkg::M_ABS_Y, m6502_oar_pkg::M_IND}) begin
              npc_r_next = request.start_pc + 16'd2;
            end else begin
              npc_r_next = request.start_pc + 16'd1;
            end
            state_next = S_B0;
          end else begin
            // Unknown mode consumes no bytes.
            npc_r_next = request.start_pc;
            state_next = S_DONE;
          end
        end
      end

      S_B0: begin
        if (mode_r == m6502_oar_pkg::M_IMM) begin
          ea_r_next  = pc_r;
          val_r_next = {8'h00, ram_rdata};
          state_next = S_DONE;
        end else if (mode_r inside {m6502_oar_pkg::M_ZP, m6502_oar_pkg::M_ZP_X,
                                    m6502_oar_pkg::M_ZP_Y}) begin
          ea_r_next  = {8'h00, zp_sum};
          ram_addr16 = {8'h00, zp_sum};
          state_next = S_VAL;
        end else if (mode_r inside {m6502_oar_pkg::M_IND_X, m6502_oar_pkg::M_IND_Y}) begin
          ptr_r_next = {8'h00, zp_sum};
          ram_addr16 = {8'h00, zp_sum};
          state_next = S_P0;
        end else begin
          // Absolute forms and indirect jump fetch a second operand byte.
          lo_r_next  = ram_rdata;
          ram_addr16 = pc_r + 16'd1;
          state_next = S_B1;
        end
      end

      S_B1: begin
        ram_addr16 = sum16;
        if (mode_r == m6502_oar_pkg::M_IND) begin
          ptr_r_next = sum16;
          state_next = S_P0;
        end else begin
          ea_r_next    = sum16;
          cross_r_next = idx_cross;
          state_next   = S_VAL;
        end
      end

      S_P0: begin
        lo_r_next = ram_rdata;
        // Indirect jump carries into the high byte; zero-page pointers wrap.
        if (mode_r == m6502_oar_pkg::M_IND) begin
          ram_addr16 = ptr_r + 16'd1;
        end else begin
          ram_addr16 = {8'h00, ptr_r[7:0] + 8'd1};
        end
        state_next = S_P1;
      end

      S_P1: begin
        ea_r_next    = sum16;
        cross_r_next = idx_cross;
        ram_addr16   = sum16;
        if (mode_r == m6502_oar_pkg::M_IND) begin
          val_r_next = sum16;
          state_next = S_DONE;
        end else begin
          state_next = S_VAL;
        end
      end

      S_VAL: begin
        val_r_next = {8'h00, ram_rdata};
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the working registers when the slot is free.
  always_comb begin
    out_valid_next = out_valid && !result.ready;
    out_ea_next    = out_ea;
    out_val_next   = out_val;
    out_cross_next = out_cross;
    out_npc_next   = out_npc;
    if (out_load) begin
      out_valid_next = 1'b1;
      out_ea_next    = ea_r;
      out_val_next   = val_r;
      out_cross_next = cross_r;
      out_npc_next   = npc_r;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    mode_r    <= mode_r_next;
    pc_r      <= pc_r_next;
    x_r       <= x_r_next;
    y_r       <= y_r_next;
    lo_r      <= lo_r_next;
    ptr_r     <= ptr_r_next;
    ea_r      <= ea_r_next;
    val_r     <= val_r_next;
    cross_r   <= cross_r_next;
    npc_r     <= npc_r_next;
    out_ea    <= out_ea_next;
    out_val   <= out_val_next;
    out_cross <= out_cross_next;
    out_npc   <= out_npc_next;
  end

  assign result.valid         = out_valid;
  assign result.eff_addr      = out_ea;
  assign result.operand_value = out_val;
  assign result.page_cross    = out_cross;
  assign result.next_pc       = out_npc;

  // The sequencer leaves idle right after taking a request.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !request.ready)
    else $error("request still ready after a transfer was taken");

  // A write command yields an all-zero result.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && request.cmd == m6502_oar_pkg::CMD_WRITE) |=>
      (state == S_DONE && ea_r == 16'h0000 && val_r == 16'h0000 &&
       !cross_r && npc_r == 16'h0000))
    else $error("write command did not produce a zero result");

  // A finished result waits while the output register is still occupied.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !result.ready) |=> (state == S_DONE))
    else $error("result dropped while the output register was full");

  // Handing off a result fills the output register and frees the sequencer.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("result hand-off did not fill the output register");

endmodule

>>> rtl/core/m6502_oar_ram.sv
// Generic single-port synchronous RAM with a registered read.
module m6502_oar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Every access reads addr into rdata, so data shows up next cycle; a write also returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
